// ----- rtl/idct_pkg.sv -----
// Shared types, constants and the cosine table of the 8x8 inverse DCT.
`default_nettype none
package idct_pkg;
  localparam int COEFF_BITS_DEFAULT = 12;
  localparam int SAMPLE_BITS = 16;
  localparam int FINAL_SHIFT = 16;
  localparam int LEVEL_SHIFT = 128;

  typedef struct packed {
    logic       load;
    logic [5:0] load_addr;
    logic       pass_col;
    logic [2:0] line;
    logic [2:0] tap;
    logic       rd;
    logic       mac;
    logic       wr_start;
    logic [2:0] wr_idx;
    logic       emit;
    logic       emit_last;
  } idct_cmd_t;

  function automatic logic signed [9:0] idct_coef(input logic [2:0] k, input logic [2:0] n);
    logic [4:0] p;
    logic       neg;
    logic [7:0] mag;
    begin
      p = 5'((32'(k) * 2 + 1) * 32'(n));
      neg = 1'b0;
      if (p > 5'd16) begin
        p = 5'd0 - p;
      end
      if (p > 5'd8) begin
        neg = 1'b1;
        p = 5'd16 - p;
      end
      case (p)
        5'd0: mag = 8'd181;
        5'd1: mag = 8'd251;
        5'd2: mag = 8'd237;
        5'd3: mag = 8'd213;
        5'd4: mag = 8'd181;
        5'd5: mag = 8'd142;
        5'd6: mag = 8'd98;
        5'd7: mag = 8'd50;
        default: mag = 8'd0;
      endcase
      if (n == 3'd0) begin
        mag = 8'd181;
        neg = 1'b0;
      end
      idct_coef = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/idct_8x8_fixed_point.sv -----
// Top level of the 8x8 fixed-point inverse DCT.
// Coefficients enter one per transfer in row-major order: a transfer happens at a
// rising edge with start high and busy low. The 64th transfer raises busy in the
// next cycle. The row pass and the column pass then take eight lines each: each
// line reads eight taps, finishes its sums and writes its eight results one per cycle.
// The 64 samples follow on consecutive cycles in row-major order, each marked by
// strobe, with last_of_block on the 64th. Busy falls while the last two samples are
// still in the output registers, and the next block may load at once. The receiver
// cannot stall.
// Reset clears the controller and the output strobe; a partly loaded block is dropped.
`default_nettype none
module idct_8x8_fixed_point #(
  parameter int COEFF_BITS = idct_pkg::COEFF_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [COEFF_BITS-1:0]         coefficient,
  output logic                                      strobe,
  output logic signed [idct_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                      last_of_block
);
  import idct_pkg::*;

  idct_cmd_t cmd;

  idct_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd));

  idct_datapath #(.COEFF_BITS(COEFF_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .coefficient(coefficient), .sample(sample),
    .last_of_block(last_of_block), .strobe_out(strobe)
  );

  assert property (@(posedge clk) disable iff (rst) last_of_block |-> strobe)
    else $error("last without strobe");
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy, 2))
    else $error("strobe while idle");
  assert property (@(posedge clk) disable iff (rst) last_of_block |=> !strobe)
    else $error("strobe after last");
endmodule
`default_nettype wire

// ----- rtl/idct_datapath.sv -----
// Datapath of the inverse DCT: coefficient and row stores and a shared multiply-accumulate.
`default_nettype none
module idct_datapath #(
  parameter int COEFF_BITS = idct_pkg::COEFF_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire idct_pkg::idct_cmd_t                   cmd,
  input  wire logic signed [COEFF_BITS-1:0]          coefficient,
  output logic signed [idct_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                       last_of_block,
  output logic                                       strobe_out
);
  import idct_pkg::*;

  localparam int ROW_BITS = COEFF_BITS + 10;
  localparam int COL_BITS = COEFF_BITS + 20;

  logic signed [COEFF_BITS-1:0] cmem [64];
  logic signed [ROW_BITS-1:0]   rmem [64];
  logic signed [COL_BITS-1:0]   cres [64];
  logic signed [ROW_BITS-1:0]   x;
  logic [2:0]                   tap_d;
  logic                         mac_d;
  logic signed [COL_BITS-1:0]   acc [8];
  logic signed [COL_BITS-1:0]   prod [8];
  logic [5:0]                   raddr;
  logic [5:0]                   waddr;
  logic signed [COL_BITS-1:0]   wv;
  logic signed [COL_BITS-1:0]   cdata;
  logic signed [COL_BITS-1:0]   ov;
  logic                         emit_d;
  logic                         last_d;

  assign raddr = cmd.pass_col ? {cmd.tap, cmd.line} : {cmd.line, cmd.tap};
  assign waddr = cmd.pass_col ? {cmd.wr_idx, cmd.line} : {cmd.line, cmd.wr_idx};
  assign wv = acc[cmd.wr_idx] >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmem[cmd.load_addr] <= coefficient;
    end
    if (cmd.rd) begin
      x <= cmd.pass_col ? rmem[raddr] : ROW_BITS'(cmem[raddr]);
    end
    tap_d <= cmd.tap;
    mac_d <= cmd.mac;
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      prod[k] = COL_BITS'(x) * COL_BITS'(idct_coef(3'(k), tap_d));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (mac_d) begin
        acc[k] <= (tap_d == 3'd0) ? prod[k] : acc[k] + prod[k];
      end
    end
    if (cmd.wr_start) begin
      if (cmd.pass_col) begin
        cres[waddr] <= wv;
      end else begin
        rmem[waddr] <= ROW_BITS'(wv);
      end
    end
    if (cmd.emit) begin
      cdata <= cres[cmd.load_addr];
    end
  end

  assign ov = cdata >>> FINAL_SHIFT;

  always_ff @(posedge clk) begin
    sample <= SAMPLE_BITS'(ov + COL_BITS'(LEVEL_SHIFT));
    if (rst) begin
      emit_d <= 1'b0;
      last_d <= 1'b0;
      last_of_block <= 1'b0;
      strobe_out <= 1'b0;
    end else begin
      emit_d <= cmd.emit;
      last_d <= cmd.emit_last;
      last_of_block <= last_d;
      strobe_out <= emit_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/idct_ctrl.sv -----
// Controller of the inverse DCT: load count, row and column pass sequencing and output.
`default_nettype none
module idct_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output idct_pkg::idct_cmd_t    cmd
);
  import idct_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  localparam logic [4:0] STEP_LAST_TAP = 5'd7;
  localparam logic [4:0] STEP_FIRST_WR = 5'd9;
  localparam logic [4:0] STEP_LAST     = 5'd16;

  logic [1:0] state;
  logic [6:0] cnt;
  logic       pcol;
  logic [2:0] line;
  logic [4:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= 7'd0;
      pcol <= 1'b0;
      line <= 3'd0;
      step <= 5'd0;
    end else begin
      case (state)
        S_LOAD: begin
          if (start) begin
            cnt <= cnt + 7'd1;
            if (cnt == 7'd63) begin
              state <= S_PASS;
              cnt <= 7'd0;
              pcol <= 1'b0;
              line <= 3'd0;
              step <= 5'd0;
            end
          end
        end
        S_PASS: begin
          if (step == STEP_LAST) begin
            step <= 5'd0;
            line <= line + 3'd1;
            if (line == 3'd7) begin
              if (pcol) begin
                state <= S_OUT;
                cnt <= 7'd0;
              end
              pcol <= ~pcol;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        S_OUT: begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) begin
            state <= S_LOAD;
            cnt <= 7'd0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_LOAD);
    cmd.pass_col = pcol;
    cmd.line = line;
    cmd.tap = step[2:0];
    cmd.load_addr = cnt[5:0];
    cmd.wr_idx = 3'd0;
    case (state)
      S_LOAD: begin
        cmd.load = start;
      end
      S_PASS: begin
        cmd.rd = (step <= STEP_LAST_TAP);
        cmd.mac = (step <= STEP_LAST_TAP);
        cmd.wr_start = (step >= STEP_FIRST_WR);
        cmd.wr_idx = 3'(step - STEP_FIRST_WR);
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        cmd.emit_last = (cnt == 7'd63);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the 8x8 fixed-point inverse DCT block.
`default_nettype none
module tb_top;
  import idct_pkg::*;

  localparam int CB = COEFF_BITS_DEFAULT;
  localparam int BLOCKS = 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_of_block;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [CB-1:0] coefficient = '0;
  logic busy, strobe, last_of_block;
  logic signed [SAMPLE_BITS-1:0] sample;

  logic signed [CB-1:0] coeff_block [64];
  int fill;
  sample_item_t expected_samples [$];
  int errors = 0;
  bit idle_on = 1'b1;

  idct_8x8_fixed_point dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .coefficient(coefficient),
    .strobe(strobe), .sample(sample), .last_of_block(last_of_block)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint floor_half(input longint v);
    return v >>> 1;
  endfunction

  task automatic idct_line(inout longint v [8]);
    longint s0, s1, s2, s3, s4, s5, e0, e1, e2, e3, o0, o1, o2, o3;
    s0 = 181 * v[0]; s1 = 181 * v[4]; s2 = 237 * v[2];
    s3 = 98 * v[2]; s4 = 237 * v[6]; s5 = 98 * v[6];
    e0 = s0 + s2 + s1 + s5; e1 = s0 + s3 - s1 - s4;
    e2 = s0 - s3 - s1 + s4; e3 = s0 - s2 + s1 - s5;
    o0 = 251 * v[1] + 213 * v[3] + 142 * v[5] + 50 * v[7];
    o1 = 213 * v[1] - 50 * v[3] - 251 * v[5] - 142 * v[7];
    o2 = 142 * v[1] - 251 * v[3] + 50 * v[5] + 213 * v[7];
    o3 = 50 * v[1] - 142 * v[3] + 213 * v[5] - 251 * v[7];
    v[0] = floor_half(e0 + o0); v[1] = floor_half(e1 + o1);
    v[2] = floor_half(e2 + o2); v[3] = floor_half(e3 + o3);
    v[4] = floor_half(e3 - o3); v[5] = floor_half(e2 - o2);
    v[6] = floor_half(e1 - o1); v[7] = floor_half(e0 - o0);
  endtask

  task automatic predict_block();
    longint m [64];
    longint v [8];
    sample_item_t it;
    for (int i = 0; i < 64; i++) m[i] = coeff_block[i];
    for (int r = 0; r < 8; r++) begin
      for (int i = 0; i < 8; i++) v[i] = m[r * 8 + i];
      idct_line(v);
      for (int i = 0; i < 8; i++) m[r * 8 + i] = v[i];
    end
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < 8; i++) v[i] = m[i * 8 + c];
      idct_line(v);
      for (int i = 0; i < 8; i++) m[i * 8 + c] = v[i];
    end
    for (int i = 0; i < 64; i++) begin
      it.sample = SAMPLE_BITS'((m[i] >>> FINAL_SHIFT) + LEVEL_SHIFT);
      it.last_of_block = (i == 63);
      expected_samples.push_back(it);
    end
  endtask

  // One coefficient transfer, with random idle cycles in front of it while idle_on is set.
  task automatic send_coeff(input logic signed [CB-1:0] c);
    while (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coefficient <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    coeff_block[fill] = c;
    fill++;
    if (fill == 64) begin
      fill = 0;
      predict_block();
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sample_item_t want;
    if (!rst && strobe) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", sample, 0);
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.sample) report_mismatch("sample", sample, want.sample);
        if (last_of_block !== want.last_of_block)
          report_mismatch("last_of_block", last_of_block, want.last_of_block);
      end
    end
  end

  // Directed row pattern: zero, both extremes, plus and minus one, 1024, -683 and 5.
  localparam int DIRECTED = 8;
  logic signed [CB-1:0] directed_pattern [DIRECTED] = '{
    12'sd0, 12'sd2047, -12'sd2048, 12'sd1, -12'sd1, 12'sd1024, -12'sd683, 12'sd5
  };

  initial begin
    logic signed [CB-1:0] c;
    fill = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed blocks: all zero, all max, checkerboard of extremes, table with DC minimum.
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 64; i++) begin
        case (d)
          0: c = '0;
          1: c = 12'sd2047;
          2: c = ((i ^ (i >> 3)) & 1) ? -12'sd2048 : 12'sd2047;
          default: c = (i == 0) ? -12'sd2048 : directed_pattern[i % DIRECTED];
        endcase
        send_coeff(c);
      end
    end
    drain();
    idle_on = 1'b0;
    for (int b = 0; b < BLOCKS; b++) begin
      for (int i = 0; i < 64; i++) begin
        if ($urandom_range(3) == 0) c = CB'($urandom);
        else c = CB'($signed(10'($urandom)) >>> $urandom_range(9));
        send_coeff(c);
      end
    end
    idle_on = 1'b1;
    // Partial block left behind: it yields no samples.
    for (int i = 0; i < 20; i++) send_coeff(CB'($urandom));
    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("idct_8x8_fixed_point verification clean");
    end else begin
      $display("idct_8x8_fixed_point verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("idct_8x8_fixed_point verification failed");
    $finish;
  end
endmodule
`default_nettype wire
